FILE: rtl/c2dv_pkg.sv
// Shared types and constants of the strided valid-window convolution block.
`timescale 1ns / 1ps
package c2dv_pkg;

   localparam int WIDTH_REG_BITS  = 9;
   localparam int KERNEL_REG_BITS = 4;
   localparam int STRIDE_REG_BITS = 4;
   localparam int CSR_DATA_BITS   = 9;
   localparam int OUT_IDX_BITS    = 8;
   localparam int SUM_BITS        = 40;
   localparam int PHASE_BITS      = 3;
   localparam int MAX_STRIDE      = 8;

   localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = 9'd28;
   localparam logic [WIDTH_REG_BITS-1:0]  HEIGHT_RESET = 9'd28;
   localparam logic [KERNEL_REG_BITS-1:0] KERNEL_RESET = 4'd3;
   localparam logic [STRIDE_REG_BITS-1:0] STRIDE_RESET = 4'd1;

   typedef enum logic [1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_KERNEL_SIZE  = 2'd2,
      CSR_STRIDE       = 2'd3
   } csr_index_type;

   typedef enum logic {
      REQ_WEIGHT = 1'b0,
      REQ_PIXEL  = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_RUN   = 2'd1,
      ST_DRAIN = 2'd2,
      ST_DONE  = 2'd3
   } state_type;

   typedef struct packed {
      logic start;
      logic rd_valid;
   } mac_ctrl_type;

endpackage

FILE: rtl/c2dv_line_store.sv
// Line store: one synchronous memory bank per kernel row, all banks read at one column.
`timescale 1ns / 1ps
module c2dv_line_store
   import c2dv_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_KERNEL = 8,
   parameter int VALUE_BITS = 16,
   parameter int CB         = 8,
   parameter int KB         = 3
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [KB-1:0]                         wr_bank,
   input  logic [CB-1:0]                         wr_addr,
   input  logic [VALUE_BITS-1:0]                 wr_data,
   input  logic [CB-1:0]                         rd_addr,
   output logic [MAX_KERNEL-1:0][VALUE_BITS-1:0] rd_data
);

   for (genvar b = 0; b < MAX_KERNEL; b++) begin : g_bank
      logic [VALUE_BITS-1:0] mem [MAX_WIDTH];

      always_ff @(posedge clock) begin
         if (wr_en && wr_bank == KB'(b)) begin
            mem[wr_addr] <= wr_data;
         end
         rd_data[b] <= mem[rd_addr];
      end
   end

endmodule

FILE: rtl/c2dv_weight_store.sv
// Weight store: one small memory per kernel row, all rows read at one kernel column.
`timescale 1ns / 1ps
module c2dv_weight_store
   import c2dv_pkg::*;
#(
   parameter int MAX_KERNEL = 8,
   parameter int VALUE_BITS = 16,
   parameter int KB         = 3
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [KB-1:0]                         wr_row,
   input  logic [KB-1:0]                         wr_col,
   input  logic [VALUE_BITS-1:0]                 wr_data,
   input  logic [KB-1:0]                         rd_col,
   output logic [MAX_KERNEL-1:0][VALUE_BITS-1:0] rd_data
);

   for (genvar r = 0; r < MAX_KERNEL; r++) begin : g_row
      logic [VALUE_BITS-1:0] mem [MAX_KERNEL];

      always_ff @(posedge clock) begin
         if (wr_en && wr_row == KB'(r)) begin
            mem[wr_col] <= wr_data;
         end
         rd_data[r] <= mem[rd_col];
      end
   end

endmodule

FILE: rtl/c2dv_mac.sv
// Multiply-accumulate lanes: one product per line bank each cycle, summed into the window total.
`timescale 1ns / 1ps
module c2dv_mac
   import c2dv_pkg::*;
#(
   parameter int MAX_KERNEL = 8,
   parameter int VALUE_BITS = 16,
   parameter int KB         = 3,
   parameter int KW         = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mac_ctrl_type                          ctrl,
   input  logic [KB-1:0]                         base_bank,
   input  logic [KW-1:0]                         kernel,
   input  logic [MAX_KERNEL-1:0][VALUE_BITS-1:0] pix,
   input  logic [MAX_KERNEL-1:0][VALUE_BITS-1:0] wgt,
   output logic signed [SUM_BITS-1:0]            acc
);

   logic signed [SUM_BITS-1:0] prod_in [MAX_KERNEL];
   logic signed [SUM_BITS-1:0] prod_ff [MAX_KERNEL];
   logic                       prod_valid_ff;
   logic signed [SUM_BITS-1:0] acc_in;
   logic signed [SUM_BITS-1:0] acc_ff;

   // Bank b holds the window row (b - base_bank) mod MAX_KERNEL.
   always_comb begin
      int                           kr;
      logic signed [2*VALUE_BITS-1:0] p;
      for (int b = 0; b < MAX_KERNEL; b++) begin
         kr = b + MAX_KERNEL - int'(base_bank);
         if (kr >= MAX_KERNEL) begin
            kr = kr - MAX_KERNEL;
         end
         p = $signed(pix[b]) * $signed(wgt[KB'(kr)]);
         if (kr < int'(kernel)) begin
            prod_in[b] = SUM_BITS'(p);
         end else begin
            prod_in[b] = '0;
         end
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.start) begin
         acc_in = '0;
      end else if (prod_valid_ff) begin
         for (int b = 0; b < MAX_KERNEL; b++) begin
            acc_in = acc_in + prod_ff[b];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= ctrl.rd_valid;
      end
      for (int b = 0; b < MAX_KERNEL; b++) begin
         prod_ff[b] <= prod_in[b];
      end
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

FILE: rtl/conv2d_valid_window_top.sv
// Strided valid 2D correlation: weight loading, raster pixel intake, window sequencing.
`timescale 1ns / 1ps
// Requests either load one kernel weight or deliver the next pixel in raster order. A weight
// request or a pixel that completes no window leaves the block idle. A pixel that completes a
// stride-aligned window starts a pass with one read per kernel column, since each line
// bank and each weight row is a memory with a single read port, followed by the memory read,
// the product register and the accumulate; no request is taken until the result is registered,
// which waits for a free output register. A finished result waits in its output register while
// the next request is taken. Any configuration write restarts the frame but keeps the weights.
module conv2d_valid_window_top
   import c2dv_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_KERNEL = 8,
   parameter int VALUE_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_type,
   input  logic [2:0]                      req_weight_row,
   input  logic [2:0]                      req_weight_col,
   input  logic signed [VALUE_BITS-1:0]    req_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [OUT_IDX_BITS-1:0]         rsp_out_col,
   output logic [OUT_IDX_BITS-1:0]         rsp_out_row,
   output logic signed [SUM_BITS-1:0]      rsp_conv_sum,
   output logic                            rsp_last_of_frame,
   input  logic                            csr_we,
   input  logic [1:0]                      csr_index,
   input  logic [CSR_DATA_BITS-1:0]        csr_wdata
);

   localparam int CB = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WW = CB + 1;
   localparam int KB = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
   localparam int KW = $clog2(MAX_KERNEL + 1);

   // Configuration
   logic [WIDTH_REG_BITS-1:0]  width_ff, width_in, height_ff, height_in;
   logic [KERNEL_REG_BITS-1:0] ksize_ff, ksize_in;
   logic [STRIDE_REG_BITS-1:0] stride_ff, stride_in;
   logic [WW-1:0]              w_eff, h_eff;
   logic [KW-1:0]              k_eff;
   logic [STRIDE_REG_BITS-1:0] s_eff;

   // Raster position
   logic [CB-1:0]           col_ff, col_in, row_ff, row_in;
   logic [PHASE_BITS-1:0]   cph_ff, cph_in, rph_ff, rph_in;
   logic [KB-1:0]           bank_ff, bank_in;
   logic [OUT_IDX_BITS-1:0] oc_ff, oc_in, orw_ff, orw_in;

   // Window sequencing
   state_type               state_ff, state_in;
   logic [KW-1:0]           kc_ff, kc_in, kreg_ff, kreg_in;
   logic [CB-1:0]           c0_ff, c0_in;
   logic [KB-1:0]           r0b_ff, r0b_in;
   logic                    drain_ff, drain_in;
   logic                    rd_valid_ff;
   logic [OUT_IDX_BITS-1:0] woc_ff, woc_in, wor_ff, wor_in;
   logic                    wlast_ff, wlast_in;

   // Result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [OUT_IDX_BITS-1:0] rcol_ff, rcol_in, rrow_ff, rrow_in;
   logic signed [SUM_BITS-1:0] rsum_ff, rsum_in;
   logic                    rlast_ff, rlast_in;

   logic accept, is_pixel, hit, row_has_win, load_rsp, issue;
   logic wgt_we;
   int   base_t;
   mac_ctrl_type mac_ctrl;
   logic [MAX_KERNEL-1:0][VALUE_BITS-1:0] pix_rd, wgt_rd;
   logic signed [SUM_BITS-1:0] acc;

   assign w_eff = (width_ff == '0) ? WW'(1) :
                  (int'(width_ff) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(width_ff);
   assign h_eff = (height_ff == '0) ? WW'(1) :
                  (int'(height_ff) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(height_ff);
   assign k_eff = (ksize_ff == '0) ? KW'(1) :
                  (int'(ksize_ff) > MAX_KERNEL) ? KW'(MAX_KERNEL) : KW'(ksize_ff);
   assign s_eff = (stride_ff == '0) ? STRIDE_REG_BITS'(1) :
                  (int'(stride_ff) > MAX_STRIDE) ? STRIDE_REG_BITS'(MAX_STRIDE) : stride_ff;

   assign accept   = req_valid && req_ready;
   assign is_pixel = (req_type == REQ_PIXEL);
   assign hit      = (int'(col_ff) + 1 >= int'(k_eff)) && (int'(row_ff) + 1 >= int'(k_eff))
                     && (cph_ff == '0) && (rph_ff == '0);
   assign row_has_win = (int'(row_ff) + 1 >= int'(k_eff)) && (rph_ff == '0)
                        && (int'(w_eff) >= int'(k_eff));
   assign wgt_we   = accept && !is_pixel && (int'(req_weight_row) < MAX_KERNEL)
                     && (int'(req_weight_col) < MAX_KERNEL);
   assign issue    = (state_ff == ST_RUN);
   assign load_rsp = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // Bank of the window's top row, a ring offset back from the current row's bank.
   always_comb begin
      base_t = int'(bank_ff) + MAX_KERNEL - (int'(k_eff) - 1);
      if (base_t >= MAX_KERNEL) begin
         base_t = base_t - MAX_KERNEL;
      end
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      ksize_in  = ksize_ff;
      stride_in = stride_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:  width_in  = csr_wdata;
            CSR_IMAGE_HEIGHT: height_in = csr_wdata;
            CSR_KERNEL_SIZE:  ksize_in  = csr_wdata[KERNEL_REG_BITS-1:0];
            CSR_STRIDE:       stride_in = csr_wdata[STRIDE_REG_BITS-1:0];
            default:          width_in  = width_ff;
         endcase
      end
   end

   // Raster position, stride phases and window counters.
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      cph_in  = cph_ff;
      rph_in  = rph_ff;
      bank_in = bank_ff;
      oc_in   = oc_ff;
      orw_in  = orw_ff;
      if (csr_we) begin
         col_in  = '0;
         row_in  = '0;
         cph_in  = '0;
         rph_in  = '0;
         bank_in = '0;
         oc_in   = '0;
         orw_in  = '0;
      end else if (accept && is_pixel) begin
         if (hit) begin
            oc_in = oc_ff + 1'b1;
         end
         if (int'(col_ff) + 1 >= int'(w_eff)) begin
            col_in = '0;
            cph_in = '0;
            oc_in  = '0;
            if (int'(row_ff) + 1 >= int'(h_eff)) begin
               row_in  = '0;
               rph_in  = '0;
               bank_in = '0;
               orw_in  = '0;
            end else begin
               row_in = row_ff + 1'b1;
               if (int'(bank_ff) + 1 >= MAX_KERNEL) begin
                  bank_in = '0;
               end else begin
                  bank_in = bank_ff + 1'b1;
               end
               if (row_has_win) begin
                  orw_in = orw_ff + 1'b1;
               end
               if (int'(row_ff) + 1 <= int'(k_eff) - 1) begin
                  rph_in = '0;
               end else if (int'(rph_ff) + 1 >= int'(s_eff)) begin
                  rph_in = '0;
               end else begin
                  rph_in = rph_ff + 1'b1;
               end
            end
         end else begin
            col_in = col_ff + 1'b1;
            if (int'(col_ff) + 1 <= int'(k_eff) - 1) begin
               cph_in = '0;
            end else if (int'(cph_ff) + 1 >= int'(s_eff)) begin
               cph_in = '0;
            end else begin
               cph_in = cph_ff + 1'b1;
            end
         end
      end
   end

   // Window sequencer.
   always_comb begin
      state_in  = state_ff;
      kc_in     = kc_ff;
      kreg_in   = kreg_ff;
      c0_in     = c0_ff;
      r0b_in    = r0b_ff;
      drain_in  = drain_ff;
      woc_in    = woc_ff;
      wor_in    = wor_ff;
      wlast_in  = wlast_ff;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (accept && is_pixel && hit) begin
               state_in = ST_RUN;
               kc_in    = '0;
               kreg_in  = k_eff;
               c0_in    = CB'(int'(col_ff) + 1 - int'(k_eff));
               r0b_in   = KB'(base_t);
               woc_in   = oc_ff;
               wor_in   = orw_ff;
               wlast_in = (int'(col_ff) + int'(s_eff) >= int'(w_eff))
                          && (int'(row_ff) + int'(s_eff) >= int'(h_eff));
            end
         end
         ST_RUN: begin
            kc_in = kc_ff + 1'b1;
            if (kc_ff + 1'b1 == kreg_ff) begin
               state_in = ST_DRAIN;
               drain_in = 1'b0;
            end
         end
         ST_DRAIN: begin
            drain_in = 1'b1;
            if (drain_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rcol_in      = rcol_ff;
      rrow_in      = rrow_ff;
      rsum_in      = rsum_ff;
      rlast_in     = rlast_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rcol_in      = woc_ff;
         rrow_in      = wor_ff;
         rsum_in      = acc;
         rlast_in     = wlast_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         ksize_ff     <= KERNEL_RESET;
         stride_ff    <= STRIDE_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         cph_ff       <= '0;
         rph_ff       <= '0;
         bank_ff      <= '0;
         oc_ff        <= '0;
         orw_ff       <= '0;
         state_ff     <= ST_IDLE;
         kc_ff        <= '0;
         drain_ff     <= 1'b0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         ksize_ff     <= ksize_in;
         stride_ff    <= stride_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         cph_ff       <= cph_in;
         rph_ff       <= rph_in;
         bank_ff      <= bank_in;
         oc_ff        <= oc_in;
         orw_ff       <= orw_in;
         state_ff     <= state_in;
         kc_ff        <= kc_in;
         drain_ff     <= drain_in;
         rd_valid_ff  <= issue;
         rsp_valid_ff <= rsp_valid_in;
      end
      kreg_ff  <= kreg_in;
      c0_ff    <= c0_in;
      r0b_ff   <= r0b_in;
      woc_ff   <= woc_in;
      wor_ff   <= wor_in;
      wlast_ff <= wlast_in;
      rcol_ff  <= rcol_in;
      rrow_ff  <= rrow_in;
      rsum_ff  <= rsum_in;
      rlast_ff <= rlast_in;
   end

   c2dv_line_store #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_KERNEL (MAX_KERNEL),
      .VALUE_BITS (VALUE_BITS),
      .CB         (CB),
      .KB         (KB)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (accept && is_pixel),
      .wr_bank (bank_ff),
      .wr_addr (col_ff),
      .wr_data (req_value),
      .rd_addr (c0_ff + CB'(kc_ff)),
      .rd_data (pix_rd)
   );

   c2dv_weight_store #(
      .MAX_KERNEL (MAX_KERNEL),
      .VALUE_BITS (VALUE_BITS),
      .KB         (KB)
   ) u_weight_store (
      .clock   (clock),
      .wr_en   (wgt_we),
      .wr_row  (KB'(req_weight_row)),
      .wr_col  (KB'(req_weight_col)),
      .wr_data (req_value),
      .rd_col  (KB'(kc_ff)),
      .rd_data (wgt_rd)
   );

   assign mac_ctrl.start    = accept && is_pixel && hit;
   assign mac_ctrl.rd_valid = rd_valid_ff;

   c2dv_mac #(
      .MAX_KERNEL (MAX_KERNEL),
      .VALUE_BITS (VALUE_BITS),
      .KB         (KB),
      .KW         (KW)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (mac_ctrl),
      .base_bank (r0b_ff),
      .kernel    (kreg_ff),
      .pix       (pix_rd),
      .wgt       (wgt_rd),
      .acc       (acc)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_col       = rcol_ff;
   assign rsp_out_row       = rrow_ff;
   assign rsp_conv_sum      = rsum_ff;
   assign rsp_last_of_frame = rlast_ff;

`ifndef SYNTHESIS
   a_kc_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (kc_ff < kreg_ff))
      else $error("kernel column counter ran past the kernel size");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result appeared without a finished window");

   a_col_in_frame: assert property (@(posedge clock) disable iff (reset)
      !csr_we |=> (int'(col_ff) < int'(w_eff)) || $past(csr_we))
      else $error("pixel column left the image");

   a_no_req_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !accept)
      else $error("request taken while a window is in progress");
`endif

endmodule

FILE: sim/conv_window_checker.sv
// Checker for the convolution block: predicts window sums from observed requests and compares.
`timescale 1ns / 1ps
module conv_window_checker
   import c2dv_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic                       req_type,
   input  logic [2:0]                 req_weight_row,
   input  logic [2:0]                 req_weight_col,
   input  logic signed [15:0]         req_value,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [OUT_IDX_BITS-1:0]    rsp_out_col,
   input  logic [OUT_IDX_BITS-1:0]    rsp_out_row,
   input  logic signed [SUM_BITS-1:0] rsp_conv_sum,
   input  logic                       rsp_last_of_frame,
   input  logic                       csr_we,
   input  logic [1:0]                 csr_index,
   input  logic [CSR_DATA_BITS-1:0]   csr_wdata,
   output int                         fail_count,
   output int                         pending
);

   typedef struct packed {
      logic [OUT_IDX_BITS-1:0] col;
      logic [OUT_IDX_BITS-1:0] row;
      logic [SUM_BITS-1:0]     sum;
      logic                    last;
   } window_result_type;

   window_result_type expected_windows[$];

   logic signed [15:0] weights[8][8];
   logic signed [15:0] lines[8][256];
   logic [WIDTH_REG_BITS-1:0]  width_reg, height_reg;
   logic [KERNEL_REG_BITS-1:0] kernel_reg;
   logic [STRIDE_REG_BITS-1:0] stride_reg;
   int col_pos, row_pos, col_ph, row_ph;

   function automatic int clamp_setting(int v, int hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
   endfunction

   task automatic restart_frame();
      col_pos = 0;
      row_pos = 0;
      col_ph = 0;
      row_ph = 0;
   endtask

   task automatic predict_pixel(logic signed [15:0] pix);
      int w, h, k, s, col, row, c0, r0;
      longint acc;
      window_result_type res;
      w = clamp_setting(width_reg, 256);
      h = clamp_setting(height_reg, 256);
      k = clamp_setting(kernel_reg, 8);
      s = clamp_setting(stride_reg, MAX_STRIDE);
      if (col_pos >= w || row_pos >= h) restart_frame();
      col = col_pos;
      row = row_pos;
      lines[row % 8][col] = pix;
      if (col + 1 >= k && row + 1 >= k && col_ph == 0 && row_ph == 0) begin
         c0 = col + 1 - k;
         r0 = row + 1 - k;
         acc = 0;
         for (int kr = 0; kr < k; kr++)
            for (int kc = 0; kc < k; kc++)
               acc += longint'(weights[kr][kc]) * longint'(lines[(r0 + kr) % 8][c0 + kc]);
         res.col = OUT_IDX_BITS'(c0 / s);
         res.row = OUT_IDX_BITS'(r0 / s);
         res.sum = acc[SUM_BITS-1:0];
         res.last = (c0 / s == (w - k) / s) && (r0 / s == (h - k) / s);
         expected_windows.push_back(res);
      end
      if (col + 1 >= w) begin
         col_pos = 0;
         col_ph = 0;
         if (row + 1 >= h) begin
            row_pos = 0;
            row_ph = 0;
         end else begin
            row_pos = row + 1;
            if (row_pos <= k - 1) row_ph = 0;
            else row_ph = (row_ph + 1 >= s) ? 0 : row_ph + 1;
         end
      end else begin
         col_pos = col + 1;
         if (col_pos <= k - 1) col_ph = 0;
         else col_ph = (col_ph + 1 >= s) ? 0 : col_ph + 1;
      end
   endtask

   always @(posedge clock) begin
      window_result_type exp_res;
      if (reset) begin
         width_reg = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         kernel_reg = KERNEL_RESET;
         stride_reg = STRIDE_RESET;
         restart_frame();
         expected_windows.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_windows.size() == 0) begin
               $display("%0t: result with nothing expected: col %0d row %0d sum %h", $time,
                        rsp_out_col, rsp_out_row, rsp_conv_sum);
               fail_count++;
            end else begin
               exp_res = expected_windows.pop_front();
               if (rsp_out_col !== exp_res.col || rsp_out_row !== exp_res.row ||
                   rsp_conv_sum !== exp_res.sum || rsp_last_of_frame !== exp_res.last) begin
                  $display("%0t: expected col %0d row %0d sum %h last %b", $time,
                           exp_res.col, exp_res.row, exp_res.sum, exp_res.last);
                  $display("%0t: actual   col %0d row %0d sum %h last %b", $time,
                           rsp_out_col, rsp_out_row, rsp_conv_sum, rsp_last_of_frame);
                  fail_count++;
               end
            end
         end
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_IMAGE_WIDTH: width_reg = csr_wdata[WIDTH_REG_BITS-1:0];
               CSR_IMAGE_HEIGHT: height_reg = csr_wdata[WIDTH_REG_BITS-1:0];
               CSR_KERNEL_SIZE: kernel_reg = csr_wdata[KERNEL_REG_BITS-1:0];
               CSR_STRIDE: stride_reg = csr_wdata[STRIDE_REG_BITS-1:0];
               default: ;
            endcase
            restart_frame();
         end
         if (req_valid && req_ready) begin
            if (req_kind_type'(req_type) == REQ_WEIGHT)
               weights[req_weight_row][req_weight_col] = req_value;
            else
               predict_pixel(req_value);
         end
      end
      pending = expected_windows.size();
   end

endmodule

FILE: sim/testbench.sv
// Testbench top: clock, reset, request and result traffic, configuration phases and verdict.
`timescale 1ns / 1ps
module testbench;
   import c2dv_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_type = 1'b0;
   logic [2:0] req_weight_row = 3'd0;
   logic [2:0] req_weight_col = 3'd0;
   logic signed [15:0] req_value = 16'sd0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [OUT_IDX_BITS-1:0] rsp_out_col, rsp_out_row;
   logic signed [SUM_BITS-1:0] rsp_conv_sum;
   logic rsp_last_of_frame;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = 2'd0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;
   int fail_count, pending;
   int items_sent = 0;
   bit sender_calm = 1'b0;

   always #5 clock = ~clock;

   conv2d_valid_window_top dut (.*);

   conv_window_checker checker_inst (.*);

   initial begin
      #3_000_000;
      $display("conv2d_valid_window_top: mismatch");
      $finish;
   end

   // The receiver stalls at random and, once, holds off long enough for the block to back up.
   initial begin
      int gap, taken;
      bit held;
      taken = 0;
      held = 1'b0;
      @(negedge reset);
      forever begin
         if (taken == 40 && !held) begin
            gap = 300;
            held = 1'b1;
         end else if ((taken / 30) % 3 == 2) begin
            gap = 0;
         end else begin
            gap = $urandom_range(0, 4);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   function automatic int clamp_setting(int v, int hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
   endfunction

   task automatic send_request(req_kind_type kind, logic [2:0] wrow, logic [2:0] wcol,
                               logic [15:0] val);
      int gap;
      if (items_sent % 60 == 0) sender_calm = $urandom_range(0, 2) == 0;
      gap = sender_calm ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_weight_row <= wrow;
      req_weight_col <= wcol;
      req_value <= val;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // Waits until every predicted window has come back and the block has had time to settle.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_value(int sel);
      case (sel % 5)
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'hffff;
         3: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic run_phase(int w_raw, int h_raw, int k_raw, int s_raw, bit extra_frame,
                            bit directed);
      int w, h, k, frame, pixels;
      logic [CSR_DATA_BITS-1:0] data[4];
      drain_results();
      data[0] = CSR_DATA_BITS'(w_raw);
      data[1] = CSR_DATA_BITS'(h_raw);
      data[2] = {5'($urandom), 4'(k_raw)};
      data[3] = {5'($urandom), 4'(s_raw)};
      for (int i = 0; i < 4; i++) begin
         csr_we <= 1'b1;
         csr_index <= 2'(i);
         csr_wdata <= data[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      w = clamp_setting(w_raw & 9'h1ff, 256);
      h = clamp_setting(h_raw & 9'h1ff, 256);
      k = clamp_setting(k_raw & 4'hf, 8);
      for (int r = 0; r < (directed ? 8 : k); r++)
         for (int c = 0; c < (directed ? 8 : k); c++)
            send_request(REQ_WEIGHT, 3'(r), 3'(c),
                         directed ? pick_value(r + c) : 16'($urandom));
      frame = w * h;
      pixels = extra_frame ? frame + $urandom_range(0, frame) : frame;
      if (pixels > 600) pixels = 600;
      for (int i = 0; i < pixels; i++) begin
         if (!directed && $urandom_range(0, 9) == 0)
            send_request(REQ_WEIGHT, 3'($urandom), 3'($urandom), 16'($urandom));
         send_request(REQ_PIXEL, 3'($urandom), 3'($urandom),
                      directed ? pick_value(i) : 16'($urandom));
      end
   endtask

   initial begin
      int w_raw, h_raw, shape;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Every weight is written here, so no window ever reads an unloaded weight.
      run_phase(4, 4, 3, 1, 1'b0, 1'b1);
      run_phase(0, 0, 0, 0, 1'b0, 1'b0);
      run_phase(511, 1, 1, 15, 1'b0, 1'b0);
      run_phase(3, 3, 15, 2, 1'b0, 1'b0);
      run_phase(10, 10, 8, 1, 1'b0, 1'b0);
      while (items_sent < 700) begin
         shape = $urandom_range(0, 9);
         if (shape == 0) begin
            w_raw = $urandom_range(200, 511);
            h_raw = $urandom_range(0, 2);
         end else if (shape == 1) begin
            w_raw = $urandom_range(0, 2);
            h_raw = $urandom_range(200, 511);
         end else begin
            w_raw = $urandom_range(0, 12);
            h_raw = $urandom_range(0, 12);
         end
         run_phase(w_raw, h_raw, $urandom_range(0, 15), $urandom_range(0, 15), 1'b1, 1'b0);
      end
      drain_results();
      if (fail_count == 0)
         $display("conv2d_valid_window_top: match");
      else
         $display("conv2d_valid_window_top: mismatch");
      $finish;
   end

endmodule
